[rtl/mts_pkg.sv]
`timescale 1ns / 1ps

package mts_pkg;

    // Operation codes carried on the func field.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Status codes reported with every result.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam int unsigned DATA_W = 32;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

[rtl/mts_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and a registered read port.
module mts_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/min_tracking_stack.sv]
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit values that also tracks the running minimum.
// Input channel (s_*): each transfer is a push of s_value (s_func = 0) or a
// pop of the top entry (s_func = 1). Result channel (m_*): exactly one
// transfer per input item, carrying the top value and minimum after the
// operation, an empty flag and a status (ok, overflow, underflow). Top and
// minimum read as zero when the stack is empty; a refused push or pop
// leaves the stack unchanged. The result is offered the cycle after the
// input transfer, except for a pop that leaves entries behind: the new top
// passes through the RAM's registered read, then the output register.
// Pushes, refused operations and pops that empty the stack run at one item
// per cycle while results are taken; a pop that reads the RAM keeps s_ready
// low, so no new item enters before its result is offered. The top entry is
// held in registers, so only that pop needs the RAM read. Reset empties the
// stack at once; no clearing pass is needed. While a result waits on
// m_ready, the output register holds it and s_ready stays low unless that
// result is taken in the same cycle.
module min_tracking_stack #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_top_value,
    output logic signed [31:0] m_min_value,
    output logic               m_is_empty,
    output logic [1:0]         m_status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned DW = mts_pkg::DATA_W;

    mts_pkg::state_t state_reg, state_next;

    logic [CW-1:0]          count_reg, count_next;
    logic signed [DW-1:0]   top_val_reg, top_val_next;
    logic signed [DW-1:0]   top_min_reg, top_min_next;

    logic                   m_valid_reg, m_valid_next;
    logic signed [DW-1:0]   m_top_reg, m_top_next;
    logic signed [DW-1:0]   m_min_reg, m_min_next;
    logic                   m_empty_reg, m_empty_next;
    logic [1:0]             m_status_reg, m_status_next;

    logic                   accept;
    logic                   is_pop;
    logic                   is_full;
    logic                   is_zero;
    logic                   pop_reads;
    logic signed [DW-1:0]   push_min;
    logic [CW-1:0]          below_idx;

    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [2*DW-1:0]        ram_rd_data;

    assign accept    = s_valid && s_ready;
    assign is_pop    = (s_func == mts_pkg::FUNC_POP);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_zero   = (count_reg == '0);
    // A pop with at least two entries exposes an entry that lives only in RAM.
    assign pop_reads = is_pop && (count_reg > CW'(1));
    assign below_idx = count_reg - CW'(2);

    // The new entry's minimum: the smaller of the value and the minimum below.
    assign push_min = (!is_zero && (top_min_reg < s_value)) ? top_min_reg : s_value;

    mts_ram #(
        .WIDTH (2 * DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({s_value, push_min}),
        .rd_en   (ram_rd_en),
        .rd_addr (below_idx[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::ST_IDLE: begin
                if (accept && pop_reads) begin
                    state_next = mts_pkg::ST_READ;
                end
            end
            mts_pkg::ST_READ: begin
                state_next = mts_pkg::ST_IDLE;
            end
            default: begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM strobes.
    always_comb begin
        s_ready   = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        case (state_reg)
            mts_pkg::ST_IDLE: begin
                s_ready   = !m_valid_reg || m_ready;
                ram_wr_en = accept && !is_pop && !is_full;
                ram_rd_en = accept && pop_reads;
            end
            mts_pkg::ST_READ: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Stack and result datapath.
    always_comb begin
        count_next    = count_reg;
        top_val_next  = top_val_reg;
        top_min_next  = top_min_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_top_next    = m_top_reg;
        m_min_next    = m_min_reg;
        m_empty_next  = m_empty_reg;
        m_status_next = m_status_reg;

        if (state_reg == mts_pkg::ST_READ) begin
            // The entry below the popped one becomes the cached top.
            top_val_next  = ram_rd_data[2*DW-1:DW];
            top_min_next  = ram_rd_data[DW-1:0];
            m_valid_next  = 1'b1;
            m_top_next    = ram_rd_data[2*DW-1:DW];
            m_min_next    = ram_rd_data[DW-1:0];
            m_empty_next  = 1'b0;
            m_status_next = mts_pkg::STATUS_OK;
        end else if (accept) begin
            if (!is_pop) begin
                if (is_full) begin
                    m_valid_next  = 1'b1;
                    m_top_next    = top_val_reg;
                    m_min_next    = top_min_reg;
                    m_empty_next  = 1'b0;
                    m_status_next = mts_pkg::STATUS_OVERFLOW;
                end else begin
                    count_next    = count_reg + CW'(1);
                    top_val_next  = s_value;
                    top_min_next  = push_min;
                    m_valid_next  = 1'b1;
                    m_top_next    = s_value;
                    m_min_next    = push_min;
                    m_empty_next  = 1'b0;
                    m_status_next = mts_pkg::STATUS_OK;
                end
            end else if (is_zero) begin
                m_valid_next  = 1'b1;
                m_top_next    = '0;
                m_min_next    = '0;
                m_empty_next  = 1'b1;
                m_status_next = mts_pkg::STATUS_UNDERFLOW;
            end else begin
                count_next = count_reg - CW'(1);
                if (!pop_reads) begin
                    // The last entry leaves; the stack is now empty.
                    m_valid_next  = 1'b1;
                    m_top_next    = '0;
                    m_min_next    = '0;
                    m_empty_next  = 1'b1;
                    m_status_next = mts_pkg::STATUS_OK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mts_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_val_reg  <= top_val_next;
        top_min_reg  <= top_min_next;
        m_top_reg    <= m_top_next;
        m_min_reg    <= m_min_next;
        m_empty_reg  <= m_empty_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = m_top_reg;
    assign m_min_value = m_min_reg;
    assign m_is_empty  = m_empty_reg;
    assign m_status    = m_status_reg;

endmodule
